[hw/rtl/isl_pkg.sv]
// Shared types and codes for the indexed sequence list unit.
// Holds request and status codes, field widths and the sequencer state type.
// No dependencies.
package isl_pkg;

	// Field widths of one request and one result
	localparam int REQ_W     = 3;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 7;

	// Request codes (req_type); other codes are no-ops
	localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REM_FIRST = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REM_LAST  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_WRITE     = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ALLOC_CAP,
		S_INS_VAL,
		S_WALK,
		S_VAL_CAP,
		S_LINK_CAP,
		S_LINK_FIX,
		S_RF_CAP,
		S_DONE
	} seq_state_t;

endpackage

[hw/rtl/isl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the value store and the link store. No dependencies.
module isl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/indexed_sequence_list_unit.sv]
// Indexed sequence list unit: bounded linked list of signed 32-bit values.
// Depends on isl_pkg and isl_ram (value store and link store).
//
// Channel  Dir  Bus     Contents (lowest bit first)
// s_*      in   tuser   req_type[2:0]
//               tdata   position[6:0], item_value[38:7], zero pad [39]
// m_*      out  tuser   status[1:0]
//               tdata   read_value[31:0], entry_count[38:32], zero pad [39]
//
// One request at a time. Head requests and tail inserts do not walk; read, write,
// remove-last and middle insert walk the links one slot per cycle. The link memory
// read port sets that pace.
// Free slots come from a high-water mark plus a free list threaded through the
// link store, so no clearing pass follows reset. A finished result sits in the
// output register; the sequencer waits in its last state only if that is full.
module indexed_sequence_list_unit import isl_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[6:0], item_value[38:7], pad[39]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], entry_count[38:32], pad[39]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	seq_state_t state_q, state_d;

	logic [REQ_W-1:0]    req_q;
	logic [PW-1:0]       pos_q;
	logic [VAL_W-1:0]    val_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       hw_q;
	logic [AW-1:0]       first_q, last_q, free_head_q;
	logic [AW-1:0]       slot_q, prev_q, cur_q;
	logic [CW-1:0]       rem_q;
	logic                pend_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    rd_q;

	logic                m_tvalid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VAL_W-1:0]    out_value_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;

	// Memory ports
	logic             link_we, link_re, val_we, val_re;
	logic [AW-1:0]    link_waddr, link_raddr, val_waddr, val_raddr;
	logic [AW-1:0]    link_wdata, link_rdata;
	logic [VAL_W-1:0] val_wdata, val_rdata;

	// Decode helpers
	logic [PW-1:0] cnt_x;
	logic          is_empty, is_one, is_full, free_avail;
	logic          pos_gt_cnt, pos_ge_cnt, pos_zero, pos_eq_cnt, ins_ok;
	logic          rem_zero, out_free;
	logic [AW-1:0] cur_w;

	assign cnt_x      = PW'(cnt_q);
	assign is_empty   = (cnt_q == '0);
	assign is_one     = (cnt_q == CW'(1));
	assign is_full    = (cnt_q == CW'(DEPTH));
	assign free_avail = (hw_q != cnt_q);
	assign pos_gt_cnt = (pos_q > cnt_x);
	assign pos_ge_cnt = (pos_q >= cnt_x);
	assign pos_zero   = (pos_q == '0);
	assign pos_eq_cnt = (pos_q == cnt_x);
	assign ins_ok     = !pos_gt_cnt && !is_full;
	assign rem_zero   = (rem_q == '0);
	assign out_free   = !m_tvalid_q || m_tready;

	// Walk pointer: after the first step the next slot comes straight from the link RAM
	assign cur_w = pend_q ? link_rdata : cur_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_value_q};
	assign m_tuser  = out_status_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				priority case (req_q)
					REQ_INSERT: begin
						if (!ins_ok)         state_d = S_DONE;
						else if (free_avail) state_d = S_ALLOC_CAP;
						else                 state_d = S_INS_VAL;
					end
					REQ_REM_FIRST: begin
						if (is_empty || is_one) state_d = S_DONE;
						else                    state_d = S_RF_CAP;
					end
					REQ_REM_LAST: begin
						if (is_empty || is_one) state_d = S_DONE;
						else                    state_d = S_WALK;
					end
					REQ_READ, REQ_WRITE: begin
						if (pos_ge_cnt) state_d = S_DONE;
						else            state_d = S_WALK;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ALLOC_CAP: state_d = S_INS_VAL;
			S_INS_VAL: begin
				if (is_empty || pos_zero || pos_eq_cnt) state_d = S_DONE;
				else                                    state_d = S_WALK;
			end
			S_WALK: begin
				if (rem_zero) begin
					priority case (req_q)
						REQ_READ:   state_d = S_VAL_CAP;
						REQ_INSERT: state_d = S_LINK_CAP;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_VAL_CAP:  state_d = S_DONE;
			S_LINK_CAP: state_d = S_LINK_FIX;
			S_LINK_FIX: state_d = S_DONE;
			S_RF_CAP:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls per state
	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = first_q;
		link_re    = 1'b0;
		link_raddr = cur_w;
		val_we     = 1'b0;
		val_waddr  = slot_q;
		val_wdata  = val_q;
		val_re     = 1'b0;
		val_raddr  = cur_w;
		unique case (state_q)
			S_DECODE: begin
				if (req_q == REQ_INSERT && ins_ok && free_avail) begin
					// pop the free list: fetch the next free slot
					link_re    = 1'b1;
					link_raddr = free_head_q;
				end else if (req_q == REQ_REM_FIRST && !is_empty) begin
					if (is_one) begin
						link_we    = 1'b1;
						link_waddr = first_q;
						link_wdata = free_head_q;
					end else begin
						link_re    = 1'b1;
						link_raddr = first_q;
					end
				end else if (req_q == REQ_REM_LAST && is_one) begin
					link_we    = 1'b1;
					link_waddr = last_q;
					link_wdata = free_head_q;
				end
			end
			S_INS_VAL: begin
				val_we = 1'b1;
				if (!is_empty && pos_zero) begin
					link_we    = 1'b1;
					link_waddr = slot_q;
					link_wdata = first_q;
				end else if (!is_empty && pos_eq_cnt) begin
					link_we    = 1'b1;
					link_waddr = last_q;
					link_wdata = slot_q;
				end
			end
			S_WALK: begin
				if (!rem_zero) begin
					link_re = 1'b1;
				end else begin
					priority case (req_q)
						REQ_READ:   val_re = 1'b1;
						REQ_WRITE: begin
							val_we    = 1'b1;
							val_waddr = cur_w;
						end
						REQ_INSERT: link_re = 1'b1;
						REQ_REM_LAST: begin
							// old tail goes onto the free list
							link_we    = 1'b1;
							link_waddr = last_q;
							link_wdata = free_head_q;
						end
						default: ;
					endcase
				end
			end
			S_LINK_CAP: begin
				link_we    = 1'b1;
				link_waddr = slot_q;
				link_wdata = link_rdata;
			end
			S_LINK_FIX: begin
				link_we    = 1'b1;
				link_waddr = prev_q;
				link_wdata = slot_q;
			end
			S_RF_CAP: begin
				link_we    = 1'b1;
				link_waddr = first_q;
				link_wdata = free_head_q;
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// List control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			hw_q    <= '0;
			first_q <= '0;
			last_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_DECODE: begin
					pend_q <= 1'b0;
					if (req_q == REQ_INSERT && ins_ok && !free_avail) begin
						hw_q <= hw_q + CW'(1);
					end
					if ((req_q == REQ_REM_FIRST || req_q == REQ_REM_LAST) && is_one) begin
						first_q <= '0;
						last_q  <= '0;
						cnt_q   <= '0;
					end
				end
				S_INS_VAL: begin
					pend_q <= 1'b0;
					if (is_empty) begin
						first_q <= slot_q;
						last_q  <= slot_q;
						cnt_q   <= cnt_q + CW'(1);
					end else if (pos_zero) begin
						first_q <= slot_q;
						cnt_q   <= cnt_q + CW'(1);
					end else if (pos_eq_cnt) begin
						last_q <= slot_q;
						cnt_q  <= cnt_q + CW'(1);
					end
				end
				S_WALK: begin
					if (!rem_zero) begin
						pend_q <= 1'b1;
					end else if (req_q == REQ_REM_LAST) begin
						last_q <= cur_w;
						cnt_q  <= cnt_q - CW'(1);
					end
				end
				S_LINK_FIX: cnt_q <= cnt_q + CW'(1);
				S_RF_CAP: begin
					first_q <= link_rdata;
					cnt_q   <= cnt_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// Request payload, walk and free-list registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					req_q    <= s_tuser;
					pos_q    <= PW'(s_tdata[POS_W-1:0]);
					val_q    <= s_tdata[POS_W+VAL_W-1:POS_W];
					status_q <= STS_OK;
					rd_q     <= '0;
				end
			end
			S_DECODE: begin
				cur_q <= first_q;
				priority case (req_q)
					REQ_INSERT: begin
						if (pos_gt_cnt)      status_q <= STS_RANGE;
						else if (is_full)    status_q <= STS_FULL;
						else if (free_avail) slot_q   <= free_head_q;
						else                 slot_q   <= hw_q[AW-1:0];
					end
					REQ_REM_FIRST, REQ_REM_LAST: begin
						if (is_empty)    status_q    <= STS_EMPTY;
						else if (is_one) free_head_q <= first_q;
						rem_q <= cnt_q - CW'(2);
					end
					REQ_READ, REQ_WRITE: begin
						if (pos_ge_cnt) status_q <= STS_RANGE;
						rem_q <= CW'(pos_q);
					end
					default: ;
				endcase
			end
			S_ALLOC_CAP: free_head_q <= link_rdata;
			S_INS_VAL: begin
				cur_q <= first_q;
				rem_q <= CW'(pos_q - PW'(1));
			end
			S_WALK: begin
				if (!rem_zero) begin
					cur_q <= cur_w;
					rem_q <= rem_q - CW'(1);
				end else if (req_q == REQ_INSERT) begin
					prev_q <= cur_w;
				end else if (req_q == REQ_REM_LAST) begin
					free_head_q <= last_q;
				end
			end
			S_VAL_CAP: rd_q <= val_rdata;
			S_RF_CAP:  free_head_q <= first_q;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= status_q;
			out_value_q  <= rd_q;
			out_cnt_q    <= CNT_OUT_W'(cnt_q);
		end
	end

	// Value store
	isl_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(val_wdata),
		.re   (val_re),
		.raddr(val_raddr),
		.rdata(val_rdata)
	);

	// Link store, also threads the free list
	isl_ram #(
		.WIDTH(AW),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

endmodule

[tb/isl_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the indexed sequence list unit testbench: a mirror of the list
// contents that predicts each result, and a queue of predicted results.
// Depends on isl_pkg for request and status codes.
package isl_tb_pkg;
	import isl_pkg::*;

	// Highest value the request field can carry; codes above REQ_WRITE do nothing
	localparam logic [REQ_W-1:0] REQ_CODE_MAX = 3'd7;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [VAL_W-1:0]     read_value;
		logic [CNT_OUT_W-1:0] entry_count;
	} list_result_t;

	class isl_list_scoreboard;
		logic signed [VAL_W-1:0] entries[$];   // list contents, head first
		list_result_t            expected_q[$];
		int                      depth;
		int                      mismatches;
		int                      results_seen;

		function new(int depth_i);
			depth        = depth_i;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function int list_size();
			return entries.size();
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply one accepted request to the mirrored list and queue its result
		function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
			list_result_t exp_r;
			int           n;
			int           p;
			n                = entries.size();
			p                = int'(pos);
			exp_r.status     = STS_OK;
			exp_r.read_value = '0;
			case (req)
				REQ_INSERT: begin
					if (p > n)
						exp_r.status = STS_RANGE;
					else if (n >= depth)
						exp_r.status = STS_FULL;
					else
						entries.insert(p, val);
				end
				REQ_REM_FIRST: begin
					if (n == 0)
						exp_r.status = STS_EMPTY;
					else
						void'(entries.pop_front());
				end
				REQ_REM_LAST: begin
					if (n == 0)
						exp_r.status = STS_EMPTY;
					else
						void'(entries.pop_back());
				end
				REQ_READ: begin
					if (p >= n)
						exp_r.status = STS_RANGE;
					else
						exp_r.read_value = entries[p];
				end
				REQ_WRITE: begin
					if (p >= n)
						exp_r.status = STS_RANGE;
					else
						entries[p] = val;
				end
				default: ;
			endcase
			exp_r.entry_count = CNT_OUT_W'(entries.size());
			expected_q.push_back(exp_r);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [STATUS_W-1:0] status, logic [VAL_W-1:0] rd,
			logic [CNT_OUT_W-1:0] cnt);
			list_result_t exp_r;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: no request pending; got status %0d value %h count %0d",
						results_seen, status, rd, cnt);
				return;
			end
			exp_r = expected_q.pop_front();
			if (status !== exp_r.status || rd !== exp_r.read_value ||
				cnt !== exp_r.entry_count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: status exp %0d got %0d, value exp %h got %h, count exp %0d got %0d",
						results_seen, exp_r.status, status, exp_r.read_value, rd,
						exp_r.entry_count, cnt);
			end
		endfunction
	endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// Top-level testbench for indexed_sequence_list_unit: directed corner requests,
// then random grow, shrink and mixed phases with random idling on both stream ports.
// Depends on isl_pkg, isl_tb_pkg and the unit's RTL.
module tb;
	import isl_pkg::*;
	import isl_tb_pkg::*;

	localparam int LIST_DEPTH   = 64;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int TAIL_CYCLES  = LIST_DEPTH + 20;

	// Random phase flavors
	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED  = 2;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position[6:0], item_value[38:7], pad[39]
	logic [2:0]  s_tuser;   // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // read_value[31:0], entry_count[38:32], pad[39]
	logic [1:0]  m_tuser;   // status[1:0]

	isl_list_scoreboard list_sb;
	bit                 steady;   // no idling on either side while set
	int                 idle_cycles;

	indexed_sequence_list_unit #(.DEPTH(LIST_DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// One request transfer; valid is only dropped when a gap comes first
	task automatic send_request(input logic [2:0] req, input logic [6:0] pos,
		input logic [31:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {1'b0, val, pos};
		do @(posedge clk); while (!s_tready);
		list_sb.note_request(req, pos, val);
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (list_sb.pending() != 0);
	endtask

	// Result side back-pressure
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			list_sb.check_result(m_tuser, m_tdata[31:0], m_tdata[38:32]);
	end

	// Watchdog: ends the run after too many cycles without any transfer
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("indexed_sequence_list_unit: mismatch");
		$finish;
	end

	// Stimulus
	initial begin
		int          items_left;
		int          block_len;
		int          mode;
		int          ins_w;
		int          rem_w;
		int          r;
		int          n;
		logic [2:0]  req;
		logic [6:0]  pos;
		logic [31:0] val;

		list_sb  = new(LIST_DEPTH);
		steady   = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_INSERT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list errors, inserts at both ends and the middle,
		// value and position extremes, overwrite, unknown codes, removals
		send_request(REQ_READ,      7'd0,   32'h0000_0000);
		send_request(REQ_WRITE,     7'd0,   32'h1234_5678);
		send_request(REQ_REM_FIRST, 7'd0,   32'h0000_0000);
		send_request(REQ_REM_LAST,  7'd0,   32'h0000_0000);
		send_request(REQ_INSERT,    7'd1,   32'h0000_0001);
		send_request(REQ_INSERT,    7'd0,   32'h8000_0000);
		send_request(REQ_INSERT,    7'd1,   32'h7fff_ffff);
		send_request(REQ_INSERT,    7'd1,   32'h0000_0000);
		send_request(REQ_INSERT,    7'd0,   32'hffff_ffff);
		send_request(REQ_READ,      7'd0,   32'h0000_0000);
		send_request(REQ_READ,      7'd1,   32'h0000_0000);
		send_request(REQ_READ,      7'd2,   32'h0000_0000);
		send_request(REQ_READ,      7'd3,   32'h0000_0000);
		send_request(REQ_WRITE,     7'd3,   32'h5555_5555);
		send_request(REQ_WRITE,     7'd1,   32'haaaa_aaaa);
		send_request(REQ_READ,      7'd3,   32'h0000_0000);
		send_request(REQ_READ,      7'd1,   32'h0000_0000);
		send_request(REQ_READ,      7'd4,   32'h0000_0000);
		send_request(REQ_READ,      7'd127, 32'h0000_0000);
		send_request(REQ_INSERT,    7'd127, 32'hffff_ffff);
		send_request(REQ_WRITE + 3'd1, 7'd127, 32'hffff_ffff);
		send_request(REQ_CODE_MAX,  7'd64,  32'h8000_0001);
		send_request(REQ_REM_LAST,  7'd0,   32'h0000_0000);
		send_request(REQ_REM_FIRST, 7'd0,   32'h0000_0000);
		send_request(REQ_READ,      7'd1,   32'h0000_0000);
		drain_results();

		// Random phases: grow toward full, shrink toward empty, or stay mixed
		items_left = RANDOM_ITEMS;
		while (items_left > 0) begin
			block_len = $urandom_range(40, 160);
			mode      = $urandom_range(MODE_GROW, MODE_MIXED);
			steady    = ($urandom_range(0, 3) == 0);
			case (mode)
				MODE_GROW:   begin ins_w = 70; rem_w = 10; end
				MODE_SHRINK: begin ins_w = 15; rem_w = 55; end
				default:     begin ins_w = 35; rem_w = 25; end
			endcase
			for (int k = 0; k < block_len && items_left > 0; k++) begin
				n   = list_sb.list_size();
				r   = $urandom_range(0, 99);
				pos = 7'($urandom_range(0, 127));
				val = $urandom;
				if (r < 2) begin
					req = 3'($urandom_range(int'(REQ_WRITE) + 1, int'(REQ_CODE_MAX)));
				end else if (r < 2 + ins_w) begin
					req = REQ_INSERT;
					if ($urandom_range(0, 9) != 0) begin
						case ($urandom_range(0, 3))
							0:       pos = 7'd0;
							1:       pos = 7'(n);
							default: pos = 7'($urandom_range(0, n));
						endcase
					end
				end else if (r < 2 + ins_w + rem_w) begin
					req = r[0] ? REQ_REM_FIRST : REQ_REM_LAST;
				end else begin
					req = r[0] ? REQ_READ : REQ_WRITE;
					if (n > 0 && $urandom_range(0, 9) != 0)
						pos = 7'($urandom_range(0, n - 1));
				end
				send_request(req, pos, val);
				if (req <= REQ_WRITE)
					items_left--;
				if ($urandom_range(0, 199) == 0)
					drain_results();
			end
		end

		// Let everything come back, then watch for stray results
		steady = 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (list_sb.mismatches == 0 && list_sb.pending() == 0)
			$display("indexed_sequence_list_unit: match");
		else
			$display("indexed_sequence_list_unit: mismatch");
		$finish;
	end

endmodule

[files.f]
hw/rtl/isl_pkg.sv
hw/rtl/isl_ram.sv
hw/rtl/indexed_sequence_list_unit.sv
tb/isl_tb_pkg.sv
tb/tb.sv
